### hw/rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int SCREENS = 4;
  localparam int CELLS_PER_SCREEN = COLS * ROWS;
  localparam int TOTAL_CELLS = CELLS_PER_SCREEN * SCREENS;
  localparam int ADDR_W = 13;
  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int SCR_W = 2;
  localparam int CELL_W = 16;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [COL_W-1:0] TAB_MASK = COL_W'(8 - 1);
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  typedef enum logic [1:0] {
    ACT_PUT = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_ACTIVE = 2'd0,
    CFG_SHOWN = 2'd1,
    CFG_ATTR = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [6:0] col_target;
    logic [4:0] row_target;
    logic [12:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic cursor_update;
    logic [12:0] cursor_address;
    logic accepted;
    logic [15:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] scr_base(input logic [SCR_W-1:0] s);
    return ADDR_W'(32'(s) * CELLS_PER_SCREEN);
  endfunction

  function automatic logic [SCR_W-1:0] clamp_scr(input logic [SCR_W-1:0] s);
    return (32'(s) >= SCREENS) ? SCR_W'(SCREENS - 1) : s;
  endfunction

endpackage

### hw/rtl/tcw_if.sv
interface tcw_in_if;
  import tcw_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/text_console_writer.sv
// put, move and read finish without a screen sweep; clear and a put that scrolls add one
// screen sweep; no new item is taken while one is in progress, and the result register
// holds off the input until its item is taken
// after reset a clearing pass writes all 8000 cells with 0x0720 before any item
// is taken; configuration registers reset to 0, 0 and 7
module text_console_writer
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tcw_in_if.sink in_ch,
  tcw_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  logic [SCR_W-1:0] active_r, shown_r;
  logic [7:0] attr_r;
  mem_req_t req;
  logic [CELL_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      shown_r <= '0;
      attr_r <= 8'd7;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ACTIVE: active_r <= cfg_data[SCR_W-1:0];
        CFG_SHOWN: shown_r <= cfg_data[SCR_W-1:0];
        CFG_ATTR: attr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .active_r, .shown_r, .attr_r, .req, .rdata
  );

  tcw_cell_ram u_ram (.clk, .req, .rdata);
endmodule

### hw/rtl/tcw_cell_ram.sv
module tcw_cell_ram
  import tcw_pkg::*;
(
  input  logic clk,
  input  mem_req_t req,
  output logic [CELL_W-1:0] rdata
);
  logic [CELL_W-1:0] mem [TOTAL_CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

### hw/rtl/tcw_ctrl.sv
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tcw_in_if.sink in_ch,
  tcw_out_if.source out_ch,
  input  logic [SCR_W-1:0] active_r,
  input  logic [SCR_W-1:0] shown_r,
  input  logic [7:0] attr_r,
  output mem_req_t req,
  input  logic [CELL_W-1:0] rdata
);
  state_t st_r, st_nxt;
  logic [ROW_W-1:0] row_r [SCREENS];
  logic [COL_W-1:0] col_r [SCREENS];
  logic [ROW_W-1:0] row_nxt;
  logic [COL_W-1:0] col_nxt;
  logic cur_we;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt, end_r, end_nxt;
  logic [ADDR_W-1:0] wptr_r, wptr_nxt;
  logic [SCR_W-1:0] scr_r, scr_nxt;
  logic upd_r, upd_nxt, acc_r, acc_nxt;
  logic ovalid_r, ovalid_nxt;
  out_item_t odata_r, odata_nxt;
  logic [CELL_W-1:0] blank;
  logic [SCR_W-1:0] scr_in;
  logic [ROW_W-1:0] r0;
  logic [COL_W-1:0] c0;
  logic [COL_W:0] cw;
  logic [ROW_W:0] rw;

  assign blank = {attr_r, CH_SPACE};
  assign scr_in = clamp_scr(active_r);
  assign r0 = row_r[scr_in];
  assign c0 = col_r[scr_in];
  assign in_ch.ready = (st_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_INIT;
      ptr_r <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < SCREENS; i++) begin
        row_r[i] <= '0;
        col_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      ptr_r <= ptr_nxt;
      ovalid_r <= ovalid_nxt;
      if (cur_we) begin
        row_r[scr_nxt] <= row_nxt;
        col_r[scr_nxt] <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    wptr_r <= wptr_nxt;
    scr_r <= scr_nxt;
    upd_r <= upd_nxt;
    acc_r <= acc_nxt;
    odata_r <= odata_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    ptr_nxt = ptr_r;
    end_nxt = end_r;
    wptr_nxt = wptr_r;
    scr_nxt = scr_r;
    upd_nxt = upd_r;
    acc_nxt = acc_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    odata_nxt = odata_r;
    cur_we = 1'b0;
    row_nxt = r0;
    col_nxt = c0;
    cw = '0;
    rw = '0;
    req = '0;
    req.wdata = blank;
    case (st_r)
      ST_INIT: begin
        req.we = 1'b1;
        req.waddr = ptr_r;
        req.wdata = RESET_CELL;
        ptr_nxt = ptr_r + 1'b1;
        if (32'(ptr_r) == TOTAL_CELLS - 1) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        scr_nxt = scr_in;
        upd_nxt = (scr_in == clamp_scr(shown_r));
        acc_nxt = 1'b1;
        req.raddr = in_ch.data.read_address;
        if (in_ch.valid && in_ch.ready) begin
          case (action_t'(in_ch.data.action))
            ACT_PUT: begin
              cur_we = 1'b1;
              cw = {1'b0, c0};
              rw = {1'b0, r0};
              if (in_ch.data.char_code == CH_BS) begin
                if (c0 != '0 || r0 != '0) begin
                  if (c0 == '0) begin
                    cw = (COL_W+1)'(COLS - 1);
                    rw = rw - 1'b1;
                  end else begin
                    cw = cw - 1'b1;
                  end
                  req.we = 1'b1;
                  req.waddr = scr_base(scr_in) + ADDR_W'(rw[ROW_W-1:0] * COLS)
                              + ADDR_W'(cw);
                end
              end else if (in_ch.data.char_code == CH_TAB) begin
                cw = (cw + (COL_W+1)'(8)) & ~{1'b0, TAB_MASK};
              end else if (in_ch.data.char_code == CH_CR) begin
                cw = '0;
              end else if (in_ch.data.char_code == CH_LF) begin
                cw = '0;
                rw = rw + 1'b1;
              end else begin
                req.we = 1'b1;
                req.waddr = scr_base(scr_in) + ADDR_W'(r0 * COLS) + ADDR_W'(c0);
                req.wdata = {attr_r, in_ch.data.char_code};
                cw = cw + 1'b1;
              end
              if (32'(cw) >= COLS) begin
                cw = '0;
                rw = rw + 1'b1;
              end
              col_nxt = cw[COL_W-1:0];
              row_nxt = rw[ROW_W-1:0];
              if (32'(rw) >= ROWS) begin
                row_nxt = ROW_W'(ROWS - 1);
                col_nxt = '0;
                ptr_nxt = scr_base(scr_in) + ADDR_W'(COLS);
                wptr_nxt = scr_base(scr_in);
                end_nxt = scr_base(scr_in) + ADDR_W'(CELLS_PER_SCREEN);
                st_nxt = ST_SCROLL_RD;
              end else begin
                st_nxt = ST_DONE;
              end
            end
            ACT_MOVE: begin
              if (32'(in_ch.data.col_target) < COLS &&
                  32'(in_ch.data.row_target) < ROWS) begin
                cur_we = 1'b1;
                col_nxt = in_ch.data.col_target;
                row_nxt = in_ch.data.row_target;
              end else begin
                acc_nxt = 1'b0;
                upd_nxt = 1'b0;
              end
              st_nxt = ST_DONE;
            end
            ACT_CLEAR: begin
              cur_we = 1'b1;
              col_nxt = '0;
              row_nxt = '0;
              wptr_nxt = scr_base(scr_in);
              end_nxt = scr_base(scr_in) + ADDR_W'(CELLS_PER_SCREEN);
              st_nxt = ST_FILL;
            end
            default: begin
              upd_nxt = 1'b0;
              ptr_nxt = in_ch.data.read_address;
              st_nxt = ST_READ_WAIT;
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        odata_nxt.cursor_update = 1'b0;
        odata_nxt.cursor_address = scr_base(scr_r) + ADDR_W'(row_r[scr_r] * COLS)
                                   + ADDR_W'(col_r[scr_r]);
        odata_nxt.accepted = 1'b1;
        odata_nxt.read_data = (32'(ptr_r) < TOTAL_CELLS) ? rdata : '0;
        ovalid_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_SCROLL_RD: begin
        req.raddr = ptr_r;
        ptr_nxt = ptr_r + ADDR_W'(1);
        st_nxt = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        req.we = 1'b1;
        req.waddr = wptr_r;
        req.wdata = rdata;
        wptr_nxt = wptr_r + 1'b1;
        req.raddr = ptr_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == end_r) begin
          st_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        req.we = 1'b1;
        req.waddr = wptr_r;
        wptr_nxt = wptr_r + 1'b1;
        if (wptr_r == end_r - 1'b1) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        odata_nxt.cursor_update = upd_r;
        odata_nxt.cursor_address = scr_base(scr_r) + ADDR_W'(row_r[scr_r] * COLS)
                                   + ADDR_W'(col_r[scr_r]);
        odata_nxt.accepted = acc_r;
        odata_nxt.read_data = '0;
        ovalid_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

### hw/rtl/tcw_checker.sv
module tcw_checker
  import tcw_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_item_t out_data
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.cursor_address) < TOTAL_CELLS) else $error("bad cursor");
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> !out_data.cursor_update) else $error("bad update");
  a_take_once: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("input taken twice");
endmodule

bind text_console_writer tcw_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

### test/tb_text_console_writer.sv
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  class console_scoreboard;
    logic [CELL_W-1:0] cells [TOTAL_CELLS];
    logic [ROW_W-1:0] crow [SCREENS];
    logic [COL_W-1:0] ccol [SCREENS];
    logic [1:0] act_scr, shown_scr;
    logic [7:0] attr;
    out_item_t pending [$];
    int errors;
    int n_results;

    function void init();
      for (int i = 0; i < TOTAL_CELLS; i++) cells[i] = RESET_CELL;
      for (int i = 0; i < SCREENS; i++) begin
        crow[i] = '0;
        ccol[i] = '0;
      end
      act_scr = 0;
      shown_scr = 0;
      attr = 8'd7;
      errors = 0;
      n_results = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [7:0] v);
      case (idx)
        CFG_ACTIVE: act_scr = v[1:0];
        CFG_SHOWN: shown_scr = v[1:0];
        CFG_ATTR: attr = v;
        default: ;
      endcase
    endfunction

    function void roll_up(int s);
      int base;
      base = s * CELLS_PER_SCREEN;
      for (int t = 0; t < CELLS_PER_SCREEN - COLS; t++) cells[base + t] = cells[base + t + COLS];
      for (int t = CELLS_PER_SCREEN - COLS; t < CELLS_PER_SCREEN; t++)
        cells[base + t] = {attr, CH_SPACE};
      crow[s] = ROW_W'(ROWS - 1);
      ccol[s] = '0;
    endfunction

    function void type_char(int s, logic [7:0] ch);
      int base, r, c;
      base = s * CELLS_PER_SCREEN;
      r = crow[s];
      c = ccol[s];
      if (ch == CH_BS) begin
        if (!(r == 0 && c == 0)) begin
          if (c == 0) begin
            c = COLS - 1;
            r--;
          end else begin
            c--;
          end
          cells[base + r * COLS + c] = {attr, CH_SPACE};
        end
      end else if (ch == CH_TAB) begin
        c = (c + 8) & ~int'(TAB_MASK);
      end else if (ch == CH_CR) begin
        c = 0;
      end else if (ch == CH_LF) begin
        c = 0;
        r++;
      end else begin
        cells[base + r * COLS + c] = {attr, ch};
        c++;
      end
      if (c >= COLS) begin
        c = 0;
        r++;
      end
      crow[s] = ROW_W'(r);
      ccol[s] = COL_W'(c);
      if (r >= ROWS) roll_up(s);
    endfunction

    function void note_item(in_item_t it);
      int s;
      bit on_view;
      out_item_t o;
      s = clamp_scr(act_scr);
      on_view = (s == clamp_scr(shown_scr));
      o = '0;
      o.accepted = 1'b1;
      case (action_t'(it.action))
        ACT_PUT: begin
          type_char(s, it.char_code);
          o.cursor_update = on_view;
        end
        ACT_MOVE: begin
          if (it.col_target < COLS && it.row_target < ROWS) begin
            ccol[s] = it.col_target;
            crow[s] = it.row_target;
            o.cursor_update = on_view;
          end else begin
            o.accepted = 1'b0;
          end
        end
        ACT_CLEAR: begin
          for (int i = 0; i < CELLS_PER_SCREEN; i++)
            cells[s * CELLS_PER_SCREEN + i] = {attr, CH_SPACE};
          crow[s] = '0;
          ccol[s] = '0;
          o.cursor_update = on_view;
        end
        default: begin
          if (it.read_address < TOTAL_CELLS) o.read_data = cells[it.read_address];
        end
      endcase
      o.cursor_address = ADDR_W'(s * CELLS_PER_SCREEN + crow[s] * COLS + ccol[s]);
      pending.push_back(o);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      n_results++;
      if (pending.size() == 0) begin
        $error("result with no expectation: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.cursor_update !== e.cursor_update) begin
        $error("cursor_update exp %0d got %0d", e.cursor_update, got.cursor_update);
        errors++;
      end
      if (got.cursor_address !== e.cursor_address) begin
        $error("cursor_address exp %0d got %0d", e.cursor_address, got.cursor_address);
        errors++;
      end
      if (got.accepted !== e.accepted) begin
        $error("accepted exp %0d got %0d", e.accepted, got.accepted);
        errors++;
      end
      if (got.read_data !== e.read_data) begin
        $error("read_data exp %h got %h", e.read_data, got.read_data);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_recv = 1'b0;

  tcw_in_if in_ch();
  tcw_out_if out_ch();
  console_scoreboard sb;

  text_console_writer u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n || hold_recv) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic in_item_t make_item(action_t a, logic [7:0] ch, int c, int r, int ra);
    in_item_t it;
    it.action = a;
    it.char_code = ch;
    it.col_target = COL_W'(c);
    it.row_target = ROW_W'(r);
    it.read_address = ADDR_W'(ra);
    return it;
  endfunction

  function automatic in_item_t random_item();
    int p;
    logic [7:0] ch;
    p = $urandom_range(99);
    ch = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: ch = CH_BS;
        1: ch = CH_TAB;
        2: ch = CH_CR;
        default: ch = CH_LF;
      endcase
    end
    if (p < 70) return make_item(ACT_PUT, ch, $urandom_range(127), $urandom_range(31),
                                 $urandom_range(8191));
    if (p < 85) begin
      if ($urandom_range(4) == 0)
        return make_item(ACT_MOVE, ch, $urandom_range(127), $urandom_range(31), 0);
      return make_item(ACT_MOVE, ch, $urandom_range(COLS - 1), $urandom_range(ROWS - 1),
                       $urandom_range(8191));
    end
    if (p < 86) return make_item(ACT_CLEAR, ch, 0, 0, 0);
    return make_item(ACT_READ, ch, $urandom_range(127), $urandom_range(31),
                     ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(7999));
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_item(random_item());
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_item(make_item(ACT_PUT, CH_BS, 0, 0, 0));
    send_item(make_item(ACT_PUT, 8'hFF, 0, 0, 0));
    send_item(make_item(ACT_PUT, 8'h00, 0, 0, 0));
    send_item(make_item(ACT_PUT, CH_TAB, 0, 0, 0));
    send_item(make_item(ACT_PUT, CH_BS, 0, 0, 0));
    send_item(make_item(ACT_PUT, CH_CR, 0, 0, 0));
    send_item(make_item(ACT_MOVE, 8'h00, COLS - 1, 1, 0));
    send_item(make_item(ACT_PUT, 8'h41, 0, 0, 0));
    send_item(make_item(ACT_PUT, CH_BS, 0, 0, 0));
    send_item(make_item(ACT_MOVE, 8'h00, 0, 1, 0));
    send_item(make_item(ACT_PUT, CH_BS, 0, 0, 0));
    send_item(make_item(ACT_MOVE, 8'h00, COLS - 3, ROWS - 1, 0));
    send_item(make_item(ACT_PUT, CH_TAB, 0, 0, 0));
    send_item(make_item(ACT_MOVE, 8'h00, COLS, 0, 0));
    send_item(make_item(ACT_MOVE, 8'h00, 0, ROWS, 0));
    send_item(make_item(ACT_MOVE, 8'h00, 127, 31, 0));
    send_item(make_item(ACT_MOVE, 8'h00, 5, ROWS - 1, 0));
    send_item(make_item(ACT_PUT, CH_LF, 0, 0, 0));
    send_item(make_item(ACT_READ, 8'h00, 0, 0, 0));
    send_item(make_item(ACT_READ, 8'h00, 0, 0, CELLS_PER_SCREEN - 1));
    send_item(make_item(ACT_READ, 8'h00, 0, 0, TOTAL_CELLS - 1));
    send_item(make_item(ACT_READ, 8'h00, 0, 0, TOTAL_CELLS));
    send_item(make_item(ACT_READ, 8'h00, 0, 0, 8191));
    send_item(make_item(ACT_CLEAR, 8'h00, 0, 0, 0));
    drain();

    send_idle = 32;
    recv_idle = 88;
    write_reg(CFG_ATTR, 8'hFF);
    write_reg(CFG_ACTIVE, 8'd3);
    write_reg(CFG_SHOWN, 8'd3);
    random_phase(250);
    drain();

    send_idle = 88;
    recv_idle = 32;
    write_reg(CFG_ATTR, 8'h00);
    write_reg(CFG_ACTIVE, 8'd1);
    write_reg(CFG_SHOWN, 8'd0);
    random_phase(250);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_ATTR, 8'h1E);
    write_reg(CFG_ACTIVE, 8'd0);
    write_reg(CFG_SHOWN, 8'd0);
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(negedge clk);
        hold_recv = 1'b0;
      end
      random_phase(100);
    join
    drain();

    write_reg(CFG_ACTIVE, 8'd2);
    write_reg(CFG_SHOWN, 8'd1);
    write_reg(CFG_ATTR, 8'($urandom_range(255)));
    random_phase(200);

    drain();
    repeat (4000) @(negedge clk);
    $display("covered put, move, clear and read over all screens and attribute extremes");
    $display("%0d results checked, %0d mismatches", sb.n_results, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_text_console_writer passed");
    end else begin
      $display("tb_text_console_writer failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_text_console_writer failed");
    $finish;
  end
endmodule

### sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_checker.sv
test/tb_text_console_writer.sv
